// ===== hw/rtl/stc_pkg.sv =====
// Shared types, constants and helpers for the SA-IS type classifier.
package stc_pkg;

    localparam int RANK_W = 9;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;

    // Separator sentinel rank used before the first symbol of a text
    localparam logic [RANK_W-1:0] SENTINEL_RANK = 9'd511;

    // Request codes on req_type
    localparam logic REQ_SYMBOL = 1'b0;
    localparam logic REQ_BIN    = 1'b1;

    typedef struct packed {
        logic advance;  // pipeline moves this cycle
        logic clear;    // item entering the read stage starts a new text
    } hist_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

// ===== hw/rtl/stc_hist.sv =====
// Length histogram memory with per-entry valid bits and write-to-read forwarding.
module stc_hist #(
    parameter int DEPTH = 101,
    parameter int AW    = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stc_pkg::hist_ctl_t       ctl,
    input  logic [AW-1:0]            rd_addr,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [stc_pkg::CNT_W-1:0] wr_data,
    output logic [stc_pkg::CNT_W-1:0] rd_value
);

    logic [stc_pkg::CNT_W-1:0] mem [DEPTH];
    logic [stc_pkg::CNT_W-1:0] rdata_reg;
    logic [DEPTH-1:0]          valid_reg;
    logic [DEPTH-1:0]          valid_next;
    logic                      vld_rd_reg;
    logic                      clr_rd_reg;
    logic                      fwd_hit_reg;
    logic [stc_pkg::CNT_W-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.advance) begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // A start clears every bin; it wins over a write from the previous text
    always_comb begin
        valid_next = valid_reg;
        if (ctl.advance && ctl.clear) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            vld_rd_reg  <= 1'b0;
            clr_rd_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.advance) begin
                vld_rd_reg  <= valid_reg[rd_addr];
                clr_rd_reg  <= ctl.clear;
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb begin
        if (clr_rd_reg) begin
            rd_value = '0;
        end else if (fwd_hit_reg) begin
            rd_value = fwd_data_reg;
        end else if (vld_rd_reg) begin
            rd_value = rdata_reg;
        end else begin
            rd_value = '0;
        end
    end

`ifndef SYNTH
    a_clear_drops_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.advance && ctl.clear) |=> (rd_value == '0))
        else $error("histogram read after start not zero");
    a_wr_needs_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.advance && ctl.clear) |=> (valid_reg == '0))
        else $error("valid bits not cleared on start");
`endif

endmodule

// ===== hw/rtl/sais_type_classifier.sv =====
// SA-IS S/L type classifier with S* substring statistics and length histogram.
// Symbols arrive from the last text position down to 0; each item yields one
// result. One item is taken every cycle while ready is high; each result passes
// through the input register, histogram read stage and result register. The
// histogram bin update is a read-modify-write spread over two stages, kept
// exact for back-to-back hits on the same bin by forwarding the last write.
// Histogram bins live in a memory with a valid flip-flop per bin, so a start
// item clears the histogram and all counters at once without stalling the input.
// Ready drops only while the result register holds an untaken result.
module sais_type_classifier #(
    parameter int MAX_TRACKED_LENGTH = 100,
    parameter int POSITION_BITS      = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic                      s_start_req,
    input  logic [7:0]                s_symbol,
    input  logic                      s_is_special,
    input  logic [31:0]               s_position,
    input  logic [6:0]                s_bin_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_s_type,
    output logic                      m_sstar_found,
    output logic [31:0]               m_sstar_length,
    output logic [31:0]               m_count_s,
    output logic [31:0]               m_count_sstar,
    output logic [63:0]               m_total_sstar_length,
    output logic [31:0]               m_longer_than_max,
    output logic [31:0]               m_bin_count
);

    localparam int LEN_W     = POSITION_BITS + 1;
    localparam int HIST_D    = MAX_TRACKED_LENGTH + 1;
    localparam int HIST_AW   = $clog2(HIST_D);
    localparam int WIDE_W    = LEN_W + HIST_AW;
    localparam int POS_X_W   = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int LEN_X_W   = (LEN_W > 32) ? LEN_W : 33;
    localparam int CW        = stc_pkg::CNT_W;
    localparam int SW        = stc_pkg::SUM_W;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- input register ----------------
    logic                     p1_valid_reg;
    logic                     p1_req_reg;
    logic                     p1_start_reg;
    logic [7:0]               p1_symbol_reg;
    logic                     p1_special_reg;
    logic [POSITION_BITS-1:0] p1_pos_reg;
    logic [6:0]               p1_bin_reg;
    logic [POS_X_W-1:0]       pos_x;

    assign pos_x = POS_X_W'(s_position);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_req_reg     <= s_req_type;
            p1_start_reg   <= s_start_req;
            p1_symbol_reg  <= s_symbol;
            p1_special_reg <= s_is_special;
            p1_pos_reg     <= pos_x[POSITION_BITS-1:0];
            p1_bin_reg     <= s_bin_index;
        end
    end

    // ---------------- classification state ----------------
    logic [stc_pkg::RANK_W-1:0] prev_rank_reg, prev_rank_next;
    logic                       prev_is_s_reg, prev_is_s_next;
    logic [LEN_W-1:0]           lbp_reg, lbp_next;
    logic [CW-1:0]              s_cnt_reg, s_cnt_next;
    logic [CW-1:0]              sstar_cnt_reg, sstar_cnt_next;
    logic [SW-1:0]              sum_reg, sum_next;
    logic [CW-1:0]              ovf_cnt_reg, ovf_cnt_next;

    logic [stc_pkg::RANK_W-1:0] rank;
    logic [stc_pkg::RANK_W-1:0] prev_rank_eff;
    logic                       prev_is_s_eff;
    logic [LEN_W-1:0]           lbp_eff;
    logic [LEN_W-1:0]           pos_ext;
    logic                       sym_item;
    logic                       cur_s;
    logic                       found;
    logic [LEN_W-1:0]           len;
    logic [LEN_X_W-1:0]         len_x;
    logic [31:0]                len_sat;
    logic [SW:0]                sum_wide;
    logic [WIDE_W-1:0]          sel_wide;
    logic                       in_range;
    logic [HIST_AW-1:0]         hist_addr;
    logic [CW-1:0]              s_base, sstar_base, ovf_base;
    logic [SW-1:0]              sum_base;

    always_comb begin
        rank          = {p1_special_reg, p1_symbol_reg};
        prev_rank_eff = p1_start_reg ? stc_pkg::SENTINEL_RANK : prev_rank_reg;
        prev_is_s_eff = p1_start_reg ? 1'b1 : prev_is_s_reg;
        pos_ext       = {1'b0, p1_pos_reg};
        lbp_eff       = p1_start_reg ? pos_ext + LEN_W'(1) : lbp_reg;
        s_base        = p1_start_reg ? '0 : s_cnt_reg;
        sstar_base    = p1_start_reg ? '0 : sstar_cnt_reg;
        ovf_base      = p1_start_reg ? '0 : ovf_cnt_reg;
        sum_base      = p1_start_reg ? '0 : sum_reg;

        sym_item = (p1_req_reg == stc_pkg::REQ_SYMBOL);
        cur_s    = (rank < prev_rank_eff) || ((rank == prev_rank_eff) && prev_is_s_eff);
        found    = sym_item && !cur_s && prev_is_s_eff;

        len     = lbp_eff - pos_ext + LEN_W'(1);
        len_x   = LEN_X_W'(len);
        len_sat = (len_x > LEN_X_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_x[31:0];

        sel_wide  = sym_item ? WIDE_W'(len) : WIDE_W'(p1_bin_reg);
        in_range  = (sel_wide <= WIDE_W'(MAX_TRACKED_LENGTH));
        hist_addr = in_range ? sel_wide[HIST_AW-1:0] : '0;

        sum_wide = {1'b0, sum_base} + (SW + 1)'(len);

        prev_rank_next = sym_item ? rank : prev_rank_eff;
        prev_is_s_next = sym_item ? cur_s : prev_is_s_eff;
        lbp_next       = found ? pos_ext : lbp_eff;
        s_cnt_next     = (sym_item && cur_s) ? stc_pkg::sat_inc(s_base) : s_base;
        sstar_cnt_next = found ? stc_pkg::sat_inc(sstar_base) : sstar_base;
        ovf_cnt_next   = (found && !in_range) ? stc_pkg::sat_inc(ovf_base) : ovf_base;
        if (!found) begin
            sum_next = sum_base;
        end else if (sum_wide[SW]) begin
            sum_next = '1;
        end else begin
            sum_next = sum_wide[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rank_reg <= stc_pkg::SENTINEL_RANK;
            prev_is_s_reg <= 1'b1;
            lbp_reg       <= '0;
            s_cnt_reg     <= '0;
            sstar_cnt_reg <= '0;
            sum_reg       <= '0;
            ovf_cnt_reg   <= '0;
        end else if (en && p1_valid_reg) begin
            prev_rank_reg <= prev_rank_next;
            prev_is_s_reg <= prev_is_s_next;
            lbp_reg       <= lbp_next;
            s_cnt_reg     <= s_cnt_next;
            sstar_cnt_reg <= sstar_cnt_next;
            sum_reg       <= sum_next;
            ovf_cnt_reg   <= ovf_cnt_next;
        end
    end

    // ---------------- histogram read stage ----------------
    logic                p2_valid_reg;
    logic                p2_req_reg;
    logic                p2_s_type_reg;
    logic                p2_found_reg;
    logic [31:0]         p2_len_reg;
    logic [CW-1:0]       p2_s_cnt_reg;
    logic [CW-1:0]       p2_sstar_cnt_reg;
    logic [SW-1:0]       p2_sum_reg;
    logic [CW-1:0]       p2_ovf_cnt_reg;
    logic                p2_in_range_reg;
    logic [HIST_AW-1:0]  p2_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_req_reg       <= p1_req_reg;
            p2_s_type_reg    <= sym_item && cur_s;
            p2_found_reg     <= found;
            p2_len_reg       <= found ? len_sat : '0;
            p2_s_cnt_reg     <= s_cnt_next;
            p2_sstar_cnt_reg <= sstar_cnt_next;
            p2_sum_reg       <= sum_next;
            p2_ovf_cnt_reg   <= ovf_cnt_next;
            p2_in_range_reg  <= in_range;
            p2_addr_reg      <= hist_addr;
        end
    end

    stc_pkg::hist_ctl_t hist_ctl;
    logic               hist_wr_en;
    logic [CW-1:0]      hist_value;

    assign hist_ctl.advance = en;
    assign hist_ctl.clear   = p1_valid_reg && p1_start_reg;
    assign hist_wr_en       = en && p2_valid_reg && p2_found_reg && p2_in_range_reg;

    stc_hist #(
        .DEPTH (HIST_D),
        .AW    (HIST_AW)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (hist_ctl),
        .rd_addr  (hist_addr),
        .wr_en    (hist_wr_en),
        .wr_addr  (p2_addr_reg),
        .wr_data  (stc_pkg::sat_inc(hist_value)),
        .rd_value (hist_value)
    );

    // ---------------- result register ----------------
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_s_type             <= p2_s_type_reg;
            m_sstar_found        <= p2_found_reg;
            m_sstar_length       <= p2_len_reg;
            m_count_s            <= p2_s_cnt_reg;
            m_count_sstar        <= p2_sstar_cnt_reg;
            m_total_sstar_length <= p2_sum_reg;
            m_longer_than_max    <= p2_ovf_cnt_reg;
            m_bin_count          <= ((p2_req_reg == stc_pkg::REQ_BIN) && p2_in_range_reg)
                                    ? hist_value : '0;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    a_found_is_l: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_sstar_found && m_s_type))
        else $error("S* boundary reported on an S-type position");
    a_len_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sstar_found) |-> (m_sstar_length == '0))
        else $error("length reported without a boundary");
    a_read_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_wr_en |-> (p2_req_reg == stc_pkg::REQ_SYMBOL))
        else $error("bin read item updated the histogram");
    a_sstar_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p1_valid_reg && !p1_start_reg && !found) |=> $stable(sstar_cnt_reg))
        else $error("S* count moved without a boundary");
`endif

endmodule
